[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lz77td_pkg.sv]
// ---------------------------------------------------------------------------
// lz77td_pkg
// Types, sizes and helpers of the LZ77 triplet decoder.
// ---------------------------------------------------------------------------
package lz77td_pkg;

	localparam int HISTORY_DEPTH  = 1024;
	localparam int BYTES_PER_BEAT = 4;
	localparam int OUT_LANES      = 4;
	localparam int LANES          = (BYTES_PER_BEAT < OUT_LANES) ? BYTES_PER_BEAT : OUT_LANES;
	localparam int LANE_W         = $clog2(LANES);
	localparam int HIST_AW        = $clog2(HISTORY_DEPTH);
	localparam int AVAIL_W        = $clog2(HISTORY_DEPTH + 1);
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [15:0] match_offset;
		logic [7:0]  match_length;
		logic [7:0]  next_byte;
		logic        first;
	} triplet_t;

	typedef struct packed {
		logic [7:0] byte_0;
		logic [7:0] byte_1;
		logic [7:0] byte_2;
		logic [7:0] byte_3;
		logic [2:0] valid_count;
		logic       last;
		logic       bad_offset;
	} beat_t;

	typedef struct packed {
		logic [AVAIL_W-1:0] offset;
		logic               off_one;
		logic [7:0]         length;
		logic [7:0]         next_byte;
		logic               bad;
	} cmd_t;

	typedef struct packed {
		logic               valid;
		logic               full;
	} queue_status_t;

	function automatic logic [HIST_AW-1:0] hist_inc(input logic [HIST_AW-1:0] a);
		return (a == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [HIST_AW-1:0] hist_sub(input logic [HIST_AW-1:0] wp,
			input logic [AVAIL_W-1:0] off);
		logic [AVAIL_W:0] w;
		logic [AVAIL_W:0] o;
		logic [AVAIL_W:0] d;
		w = (AVAIL_W+1)'(wp);
		o = (AVAIL_W+1)'(off);
		if (w >= o) begin
			d = w - o;
		end else begin
			d = w + (AVAIL_W+1)'(HISTORY_DEPTH) - o;
		end
		return d[HIST_AW-1:0];
	endfunction

endpackage

[rtl/lz77_triplet_decoder.sv]
// ---------------------------------------------------------------------------
// lz77_triplet_decoder
// LZ77 triplet decoder: expand triplets from a history ring into byte beats.
// ---------------------------------------------------------------------------
//  channel   payload     valid          stall          item
//  in        triplet     triplet_valid  triplet_stall  one LZ77 triplet
//  out       beat        beat_valid     beat_stall     up to four bytes
//
//  The front takes one triplet per cycle into a two-entry command queue.
//  The back moves one byte per cycle through the history memory port; a
//  literal or bad offset stays in ST_IDLE; copies pass ST_COPY and ST_NEXT.
//  Reset clears control state only; no memory clearing pass is needed.
//  Output stall freezes the back; the front runs until the queue fills.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lz77_triplet_decoder import lz77td_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  triplet_t triplet,
	input  logic     triplet_valid,
	output logic     triplet_stall,
	output beat_t    beat,
	output logic     beat_valid,
	input  logic     beat_stall
);

	queue_status_t q_status;
	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	cmd_t          head;

	lz77td_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.triplet      (triplet),
		.triplet_valid(triplet_valid),
		.triplet_stall(triplet_stall),
		.q_status     (q_status),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	lz77td_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	lz77td_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.beat      (beat),
		.beat_valid(beat_valid),
		.beat_stall(beat_stall)
	);

	`ASSERT_IMPLIES(a_bad_beat_empty, clk, arst_n, beat_valid && beat.bad_offset,
		beat.valid_count == 3'd0 && beat.last, "bad offset beat carries data")
	`ASSERT_IMPLIES(a_good_beat_filled, clk, arst_n, beat_valid && !beat.bad_offset,
		beat.valid_count != 3'd0 && beat.valid_count <= 3'(LANES), "beat count out of range")
	`ASSERT_IMPLIES(a_inner_beat_full, clk, arst_n, beat_valid && !beat.last,
		beat.valid_count == 3'(LANES), "short beat before end of triplet")
	`ASSERT_NEXT(a_pop_needs_entry, clk, arst_n, !q_status.valid,
		!(pop && !q_status.valid), "pop from empty queue")

endmodule

[rtl/lz77td_ram.sv]
// ---------------------------------------------------------------------------
// lz77td_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lz77td_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/lz77td_queue.sv]
// ---------------------------------------------------------------------------
// lz77td_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module lz77td_queue import lz77td_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          push_cmd,
	input  logic          pop,
	output cmd_t          head,
	output queue_status_t status
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.valid = (count_q != '0);
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/lz77td_front.sv]
// ---------------------------------------------------------------------------
// lz77td_front
// Accept triplets, track stream history length, flag bad offsets.
// ---------------------------------------------------------------------------
module lz77td_front import lz77td_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  triplet_t      triplet,
	input  logic          triplet_valid,
	output logic          triplet_stall,
	input  queue_status_t q_status,
	output logic          push,
	output cmd_t          push_cmd
);

	logic [AVAIL_W-1:0] avail_q;
	logic [AVAIL_W-1:0] avail_cur;
	logic [AVAIL_W+8:0] avail_sum;
	logic               bad;

	assign triplet_stall = q_status.full;
	assign push          = triplet_valid && !q_status.full;

	assign avail_cur = triplet.first ? '0 : avail_q;
	assign bad = (triplet.match_length != '0) &&
		((triplet.match_offset == '0) || (17'(triplet.match_offset) > 17'(avail_cur)));
	assign avail_sum = (AVAIL_W+9)'(avail_cur) + (AVAIL_W+9)'(triplet.match_length) + 1'b1;

	always_comb begin
		push_cmd.offset    = triplet.match_offset[AVAIL_W-1:0];
		push_cmd.off_one   = (triplet.match_offset == 16'd1);
		push_cmd.length    = triplet.match_length;
		push_cmd.next_byte = triplet.next_byte;
		push_cmd.bad       = bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q <= '0;
		end else if (push) begin
			if (bad) begin
				avail_q <= avail_cur;
			end else if (avail_sum >= (AVAIL_W+9)'(HISTORY_DEPTH)) begin
				avail_q <= AVAIL_W'(HISTORY_DEPTH);
			end else begin
				avail_q <= avail_sum[AVAIL_W-1:0];
			end
		end
	end

endmodule

[rtl/lz77td_back.sv]
// ---------------------------------------------------------------------------
// lz77td_back
// Execute commands against the history memory and pack bytes into beats.
// ---------------------------------------------------------------------------
module lz77td_back import lz77td_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          head,
	input  queue_status_t q_status,
	output logic          pop,
	output beat_t         beat,
	output logic          beat_valid,
	input  logic          beat_stall
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COPY = 2'd1;
	localparam logic [1:0] ST_NEXT = 2'd2;

	logic [1:0]         state_q;
	logic [HIST_AW-1:0] wp_q;
	logic [HIST_AW-1:0] src_q;
	logic [7:0]         rem_q;
	logic [7:0]         next_q;
	logic [7:0]         last_q;
	logic               off_one_q;
	logic               lead_q;

	logic               we;
	logic [7:0]         wdata;
	logic               re;
	logic [HIST_AW-1:0] raddr;
	logic [7:0]         rdata;
	logic [7:0]         copy_byte;

	logic               pk_rdy;
	logic               pk_push;
	logic               pk_end;
	logic               pk_bad;

	logic [7:0]         asm_q [LANES];
	logic [LANE_W-1:0]  asm_cnt_q;
	logic [7:0]         lane [OUT_LANES];
	logic [2:0]         fill;
	logic               complete;
	beat_t              beat_nxt;

	lz77td_ram #(
		.WIDTH(8),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (we),
		.waddr(wp_q),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign pk_rdy    = !beat_valid || !beat_stall;
	assign copy_byte = (off_one_q && !lead_q) ? last_q : rdata;

	always_comb begin
		pop     = 1'b0;
		we      = 1'b0;
		wdata   = head.next_byte;
		re      = 1'b0;
		raddr   = hist_sub(wp_q, head.offset);
		pk_push = 1'b0;
		pk_end  = 1'b0;
		pk_bad  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_status.valid && pk_rdy) begin
					pop = 1'b1;
					if (head.bad) begin
						pk_push = 1'b1;
						pk_end  = 1'b1;
						pk_bad  = 1'b1;
					end else if (head.length == '0) begin
						we      = 1'b1;
						pk_push = 1'b1;
						pk_end  = 1'b1;
					end else begin
						re = 1'b1;
					end
				end
			end
			ST_COPY: begin
				raddr = src_q;
				wdata = copy_byte;
				if (pk_rdy) begin
					we      = 1'b1;
					pk_push = 1'b1;
					re      = (rem_q != '0);
				end
			end
			ST_NEXT: begin
				wdata = next_q;
				if (pk_rdy) begin
					we      = 1'b1;
					pk_push = 1'b1;
					pk_end  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			src_q     <= '0;
			rem_q     <= '0;
			off_one_q <= 1'b0;
			lead_q    <= 1'b0;
		end else begin
			if (we) begin
				wp_q   <= hist_inc(wp_q);
				lead_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && !head.bad && head.length != '0) begin
						src_q     <= hist_inc(raddr);
						rem_q     <= head.length - 1'b1;
						off_one_q <= head.off_one;
						lead_q    <= 1'b1;
						state_q   <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (pk_rdy) begin
						if (rem_q != '0) begin
							src_q <= hist_inc(src_q);
							rem_q <= rem_q - 1'b1;
						end else begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					if (pk_rdy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			last_q <= wdata;
		end
		if (pop) begin
			next_q <= head.next_byte;
		end
	end

	always_comb begin
		for (int i = 0; i < OUT_LANES; i++) begin
			if (i < LANES && LANE_W'(i) == asm_cnt_q) begin
				lane[i] = wdata;
			end else if (i < LANES && LANE_W'(i) < asm_cnt_q) begin
				lane[i] = asm_q[i % LANES];
			end else begin
				lane[i] = '0;
			end
		end
		fill     = 3'(asm_cnt_q) + 3'd1;
		complete = pk_push && (pk_bad || pk_end || asm_cnt_q == LANE_W'(LANES - 1));
		if (pk_bad) begin
			beat_nxt = '0;
			beat_nxt.last       = 1'b1;
			beat_nxt.bad_offset = 1'b1;
		end else begin
			beat_nxt.byte_0      = lane[0];
			beat_nxt.byte_1      = lane[1];
			beat_nxt.byte_2      = lane[2];
			beat_nxt.byte_3      = lane[3];
			beat_nxt.valid_count = fill;
			beat_nxt.last        = pk_end;
			beat_nxt.bad_offset  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_cnt_q  <= '0;
			beat_valid <= 1'b0;
		end else begin
			if (complete) begin
				beat_valid <= 1'b1;
			end else if (beat_valid && !beat_stall) begin
				beat_valid <= 1'b0;
			end
			if (complete) begin
				asm_cnt_q <= '0;
			end else if (pk_push) begin
				asm_cnt_q <= asm_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			beat <= beat_nxt;
		end
		if (pk_push && !complete) begin
			asm_q[asm_cnt_q] <= wdata;
		end
	end

endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// LZ77 triplet decoder testbench
// Sends triplets through the valid/stall input channel and checks every output
// beat against a predictor that keeps its own history ring, write pointer and
// available-byte count. Directed cases cover literals, bad distances,
// overlapping copies, beat tails and history wrap. Backpressure runs and
// random streams follow, with random idling on both channels.
// ---------------------------------------------------------------------------
module testbench import lz77td_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	logic     clk           = 1'b0;
	logic     arst_n        = 1'b0;
	triplet_t triplet       = '0;
	logic     triplet_valid = 1'b0;
	logic     triplet_stall;
	beat_t    beat;
	logic     beat_valid;
	logic     beat_stall    = 1'b0;

	logic [7:0] model_history [HISTORY_DEPTH];
	int         model_wp    = 0;
	int         model_avail = 0;
	beat_t      expected_beats [$];

	int errors          = 0;
	bit idle_on         = 1'b1;
	int rx_hold_request = 0;

	lz77_triplet_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.triplet       (triplet),
		.triplet_valid (triplet_valid),
		.triplet_stall (triplet_stall),
		.beat          (beat),
		.beat_valid    (beat_valid),
		.beat_stall    (beat_stall)
	);

	always #2 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 15);
		if (r < 8) begin
			return 0;
		end else if (r < 14) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic triplet_t make_triplet(input int off, input int len, input int nb,
			input bit first);
		triplet_t t;
		t.match_offset = off[15:0];
		t.match_length = len[7:0];
		t.next_byte    = nb[7:0];
		t.first        = first;
		return t;
	endfunction

	task automatic store_byte(input logic [7:0] b);
		model_history[model_wp] = b;
		model_wp = (model_wp + 1) % HISTORY_DEPTH;
		if (model_avail < HISTORY_DEPTH) begin
			model_avail++;
		end
	endtask

	task automatic expand_triplet(input triplet_t t);
		logic [7:0] produced [$];
		logic [7:0] lane [4];
		beat_t      b;
		int         src;
		int         pos;
		int         n;
		int         i;
		if (t.first) begin
			model_avail = 0;
		end
		if (t.match_length != 0 &&
				(t.match_offset == 0 || int'(t.match_offset) > model_avail)) begin
			b = '0;
			b.last = 1'b1;
			b.bad_offset = 1'b1;
			expected_beats.push_back(b);
			return;
		end
		for (i = 0; i < int'(t.match_length); i++) begin
			src = (model_wp + HISTORY_DEPTH - int'(t.match_offset)) % HISTORY_DEPTH;
			produced.push_back(model_history[src]);
			store_byte(model_history[src]);
		end
		produced.push_back(t.next_byte);
		store_byte(t.next_byte);
		pos = 0;
		while (pos < produced.size()) begin
			n = produced.size() - pos;
			if (n > LANES) begin
				n = LANES;
			end
			for (i = 0; i < 4; i++) begin
				lane[i] = (i < n) ? produced[pos + i] : 8'h00;
			end
			b = '0;
			b.byte_0 = lane[0];
			b.byte_1 = lane[1];
			b.byte_2 = lane[2];
			b.byte_3 = lane[3];
			b.valid_count = n[2:0];
			pos += n;
			b.last = (pos >= produced.size());
			expected_beats.push_back(b);
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	task automatic check_beat(input beat_t got);
		beat_t want;
		if (expected_beats.size() == 0) begin
			$error("beat: expected none, actual %0h", got);
			errors++;
			return;
		end
		want = expected_beats.pop_front();
		compare_field("byte_0", want.byte_0, got.byte_0);
		compare_field("byte_1", want.byte_1, got.byte_1);
		compare_field("byte_2", want.byte_2, got.byte_2);
		compare_field("byte_3", want.byte_3, got.byte_3);
		compare_field("valid_count", want.valid_count, got.valid_count);
		compare_field("last", want.last, got.last);
		compare_field("bad_offset", want.bad_offset, got.bad_offset);
	endtask

	// output side: check each transfer, then pick the stall for the next cycle
	initial begin
		int hold_left;
		int stall_run;
		hold_left = 0;
		stall_run = 0;
		forever begin
			@(posedge clk);
			if (arst_n && beat_valid && !beat_stall) begin
				check_beat(beat);
			end
			if (rx_hold_request > 0) begin
				hold_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				beat_stall <= 1'b1;
			end else begin
				if (stall_run == 0 && idle_on && $urandom_range(0, 3) == 0) begin
					stall_run = pick_gap();
				end
				beat_stall <= (stall_run > 0);
				if (stall_run > 0) begin
					stall_run--;
				end
			end
		end
	end

	task automatic send_triplet(input triplet_t t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			triplet_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		triplet <= t;
		triplet_valid <= 1'b1;
		@(posedge clk);
		while (triplet_stall) begin
			@(posedge clk);
		end
		expand_triplet(t);
	endtask

	task automatic wait_drained();
		triplet_valid <= 1'b0;
		while (expected_beats.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic triplet_t random_good(input bit first);
		int len;
		int off;
		int r;
		r = $urandom_range(0, 15);
		if (first || model_avail == 0 || r < 3) begin
			return make_triplet($urandom_range(0, 65535), 0, $urandom_range(0, 255), first);
		end
		if (r < 13) begin
			len = $urandom_range(1, 12);
		end else begin
			len = $urandom_range(13, 255);
		end
		if ($urandom_range(0, 1) == 0) begin
			off = $urandom_range(1, (model_avail < 8) ? model_avail : 8);
		end else begin
			off = $urandom_range(1, model_avail);
		end
		return make_triplet(off, len, $urandom_range(0, 255), 1'b0);
	endfunction

	function automatic triplet_t random_bad();
		int off;
		if ($urandom_range(0, 1) == 0) begin
			off = 0;
		end else begin
			off = $urandom_range(model_avail + 1, 65535);
		end
		return make_triplet(off, $urandom_range(1, 255), $urandom_range(0, 255), 1'b0);
	endfunction

	task automatic test_literals();
		send_triplet(make_triplet(16'hFFFF, 0, 8'h00, 1'b1));
		send_triplet(make_triplet(16'h8000, 0, 8'hFF, 1'b0));
		send_triplet(make_triplet(0, 0, 8'hA5, 1'b0));
		send_triplet(make_triplet(1, 0, 8'h3C, 1'b1));
	endtask

	task automatic test_bad_distance();
		send_triplet(make_triplet(1, 1, 8'h22, 1'b1));
		send_triplet(make_triplet(0, 0, 8'h11, 1'b0));
		send_triplet(make_triplet(0, 5, 8'h33, 1'b0));
		send_triplet(make_triplet(2, 1, 8'h44, 1'b0));
		send_triplet(make_triplet(16'hFFFF, 255, 8'h55, 1'b0));
	endtask

	task automatic test_copies();
		send_triplet(make_triplet(0, 0, 8'hC3, 1'b1));
		send_triplet(make_triplet(1, 255, 8'h7E, 1'b0));
		send_triplet(make_triplet(257, 1, 8'h81, 1'b0));
		send_triplet(make_triplet(4, 2, 8'h18, 1'b0));
		send_triplet(make_triplet(100, 3, 8'hE7, 1'b0));
	endtask

	task automatic test_history_wrap();
		send_triplet(make_triplet(0, 0, 8'h5A, 1'b1));
		send_triplet(make_triplet(1, 0, 8'h96, 1'b0));
		send_triplet(make_triplet(2, 255, 8'h01, 1'b0));
		send_triplet(make_triplet(3, 255, 8'h02, 1'b0));
		send_triplet(make_triplet(7, 255, 8'h04, 1'b0));
		send_triplet(make_triplet(200, 255, 8'h08, 1'b0));
		send_triplet(make_triplet(HISTORY_DEPTH, 255, 8'h10, 1'b0));
		send_triplet(make_triplet(HISTORY_DEPTH + 1, 1, 8'h20, 1'b0));
	endtask

	task automatic test_output_hold();
		int i;
		rx_hold_request = 200;
		for (i = 0; i < 10; i++) begin
			send_triplet(random_good(1'b0));
		end
	endtask

	task automatic test_drain_pause();
		wait_drained();
		send_triplet(random_good(1'b1));
		send_triplet(random_good(1'b0));
	endtask

	task automatic test_random_streams(input int n_items);
		int       sent;
		int       stream_left;
		int       r;
		triplet_t t;
		sent = 0;
		stream_left = 0;
		while (sent < n_items) begin
			idle_on = ((sent / 25) % 3) != 2;
			if (stream_left == 0) begin
				stream_left = $urandom_range(3, 30);
				t = random_good(1'b1);
			end else begin
				r = $urandom_range(0, 19);
				if (r == 0) begin
					t = random_bad();
				end else if (r == 1) begin
					t = make_triplet($urandom_range(0, 65535), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 1));
				end else begin
					t = random_good(1'b0);
				end
			end
			stream_left--;
			send_triplet(t);
			sent++;
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_literals();
		test_bad_distance();
		test_copies();
		test_history_wrap();
		test_output_hold();
		test_drain_pause();
		test_random_streams(116);
		wait_drained();
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
